/* rtl/wmed_pkg.sv */
// Package with the shared types and constants of the window median selector.
package wmed_pkg;

   localparam int PIXEL_W = 8;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // Control word broadcast from the top level to every cell of the sort chain.
   typedef struct packed {
      logic insert;
      logic clear;
   } cell_ctl_type;

endpackage

/* rtl/wmed_if.sv */
// Valid/ready channel interfaces for the pixel input and the median result.
interface wmed_req_if;
   logic                valid;
   logic                ready;
   wmed_pkg::pixel_type pixel;
   logic                last;

   modport source (output valid, output pixel, output last, input ready);
   modport sink (input valid, input pixel, input last, output ready);
endinterface

interface wmed_rsp_if;
   logic                valid;
   logic                ready;
   wmed_pkg::pixel_type median;
   logic                overflow;

   modport source (output valid, output median, output overflow, input ready);
   modport sink (input valid, input median, input overflow, output ready);
endinterface

/* rtl/wmed_cell.sv */
// One cell of the insertion-sort chain: holds one sorted pixel and its valid bit.
module wmed_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  wmed_pkg::cell_ctl_type ctl,
   input  wmed_pkg::pixel_type    px,
   input  wmed_pkg::pixel_type    left_val,
   input  logic                   left_gt,
   input  logic                   left_valid,
   output wmed_pkg::pixel_type    val,
   output logic                   gt,
   output logic                   valid
);

   wmed_pkg::pixel_type val_ff, val_in;
   logic                valid_ff, valid_in;

   // An empty cell behaves as if it held a value above every pixel.
   assign gt    = !valid_ff || (val_ff > px);
   assign val   = val_ff;
   assign valid = valid_ff;

   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert) begin
         // Larger entries shift up one cell; the first larger slot takes the pixel.
         if (left_gt) begin
            val_in = left_val;
         end else if (gt) begin
            val_in = px;
         end
         valid_in = valid_ff | left_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      val_ff <= val_in;
   end

endmodule

/* rtl/window_median_select_core.sv */
// Top level of the window median selector: sort chain, window counter, result register.
//
//   channel   direction  words                    handshake
//   req_ch    in         pixel[7:0], last         valid/ready
//   rsp_ch    out        median[7:0], overflow    valid/ready
//
// A pixel word is taken while req_ch.ready is high; a non-full chain inserts it in
// sorted order. After a word with last set, req_ch.ready stays low through the closing
// cycle, in which the median cell goes into the result register and the chain is cleared.
// If the result register is still full, that closing cycle waits until rsp_ch takes it.
// Reset is synchronous and empties the chain and the result register.
module window_median_select_core #(
   parameter int MAX_WINDOW = 32
) (
   input  logic       clock,
   input  logic       reset,
   wmed_req_if.sink   req_ch,
   wmed_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                dropped_ff, dropped_in;
   logic                pending_ff, pending_in;
   logic                rsp_valid_ff, rsp_valid_in;
   wmed_pkg::pixel_type median_ff, median_in;
   logic                overflow_ff, overflow_in;

   logic                   accept;
   logic                   full;
   logic                   fire;
   logic [CNT_W-1:0]       rank_full;
   logic [IDX_W-1:0]       rank_idx;
   wmed_pkg::cell_ctl_type ctl;

   wmed_pkg::pixel_type cell_val   [MAX_WINDOW];
   logic                cell_gt    [MAX_WINDOW];
   logic                cell_valid [MAX_WINDOW];

   assign req_ch.ready    = !pending_ff;
   assign accept          = req_ch.valid && req_ch.ready;
   assign full            = (count_ff == CNT_W'(MAX_WINDOW));
   assign fire            = pending_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign rank_full       = count_ff >> 1;
   assign rank_idx        = rank_full[IDX_W-1:0];

   assign ctl.insert = accept && !full;
   assign ctl.clear  = fire;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      wmed_pkg::pixel_type left_val;
      logic                left_gt;
      logic                left_valid;

      if (i == 0) begin : g_head
         assign left_val   = '0;
         assign left_gt    = 1'b0;
         assign left_valid = 1'b1;
      end else begin : g_body
         assign left_val   = cell_val[i-1];
         assign left_gt    = cell_gt[i-1];
         assign left_valid = cell_valid[i-1];
      end

      wmed_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .px         (req_ch.pixel),
         .left_val   (left_val),
         .left_gt    (left_gt),
         .left_valid (left_valid),
         .val        (cell_val[i]),
         .gt         (cell_gt[i]),
         .valid      (cell_valid[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff;
      median_in    = median_ff;
      overflow_in  = overflow_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
         pending_in = req_ch.last;
      end

      // A window never closes empty, so the rank cell always holds a pixel.
      if (fire) begin
         median_in    = cell_val[rank_idx];
         overflow_in  = dropped_ff;
         rsp_valid_in = 1'b1;
         count_in     = '0;
         dropped_in   = 1'b0;
         pending_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      median_ff   <= median_in;
      overflow_ff <= overflow_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.median   = median_ff;
   assign rsp_ch.overflow = overflow_ff;

endmodule

/* rtl/wmed_checker.sv */
// Port-level checker for the window median selector, bound to the top level.
module wmed_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_last,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input wmed_pkg::pixel_type rsp_median,
   input logic                rsp_overflow
);

   // A result word that is not taken holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median) && $stable(rsp_overflow))
      else $error("result word changed or dropped while stalled");

   // Accepting a closing word drops req_ready in the cycle after it.
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("pixel accepted right after a closing word");

   // A pixel inside a window never stops the input.
   a_open_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last |=> req_ready)
      else $error("input stalled in the middle of a window");

   // Reset leaves no result behind.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind window_median_select_core wmed_checker u_wmed_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_last     (req_ch.last),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_median   (rsp_ch.median),
   .rsp_overflow (rsp_ch.overflow)
);

/* bench/window_median_select_core_tb.sv */
// Self-checking testbench for the window median selector core.
module window_median_select_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_DEPTH = 32;
   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 50;
   localparam int PHASE_WORDS  = 190;
   localparam int HOLD_CYCLES  = 300;
   localparam int N_ROWS       = 21;

   typedef struct packed {
      wmed_pkg::pixel_type median;
      logic                overflow;
   } median_word_type;

   // One row of the directed table: count copies of pixel, the final one closing the
   // window when close is set; typed rows carry the expected median word.
   typedef struct packed {
      wmed_pkg::pixel_type pixel;
      logic [7:0]          count;
      logic                close;
      logic                typed;
      wmed_pkg::pixel_type exp_median;
      logic                exp_overflow;
   } stim_row_type;

   typedef enum int {SPREAD, CLUSTER, EXTREMES, DESCENDING} pixel_style_type;

   logic clock;
   logic reset;

   wmed_req_if req_ch_if ();
   wmed_rsp_if rsp_ch_if ();

   window_median_select_core #(
      .MAX_WINDOW(WINDOW_DEPTH)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch_if),
      .rsp_ch(rsp_ch_if)
   );

   stim_row_type stim_rows [N_ROWS] = '{
      '{8'd0,   8'd1,  1'b1, 1'b1, 8'd0,   1'b0},
      '{8'd255, 8'd1,  1'b1, 1'b1, 8'd255, 1'b0},
      '{8'd10,  8'd1,  1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd20,  8'd1,  1'b1, 1'b1, 8'd20,  1'b0},
      '{8'd30,  8'd1,  1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd10,  8'd1,  1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd20,  8'd1,  1'b1, 1'b1, 8'd20,  1'b0},
      '{8'd50,  8'd1,  1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd200, 8'd1,  1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd3,   8'd2,  1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd128, 8'd1,  1'b1, 1'b0, 8'd0,   1'b0},
      '{8'd0,   8'd16, 1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd255, 8'd16, 1'b1, 1'b1, 8'd255, 1'b0},
      '{8'd200, 8'd32, 1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd5,   8'd1,  1'b1, 1'b1, 8'd200, 1'b1},
      '{8'd1,   8'd20, 1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd250, 8'd20, 1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd3,   8'd1,  1'b1, 1'b1, 8'd1,   1'b1},
      '{8'd85,  8'd1,  1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd170, 8'd1,  1'b1, 1'b0, 8'd0,   1'b0},
      '{8'd77,  8'd1,  1'b1, 1'b1, 8'd77,  1'b0}
   };

   int idle_mix  [4] = '{0, 47, 0, 31};
   int stall_mix [4] = '{0, 0, 47, 31};

   // Predictor state: the pixels held in the current window, kept in ascending order.
   wmed_pkg::pixel_type window_px [$];
   logic                window_dropped = 1'b0;

   median_word_type pending_medians [$];

   // Side data that travels with the word on the request channel.
   logic            word_typed;
   median_word_type word_fixed;

   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_request  = 0;
   int words_sent    = 0;
   int words_taken   = 0;
   int windows_seen  = 0;
   int overflow_seen = 0;
   int medians_seen  = 0;
   int mismatches    = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void absorb_pixel(wmed_pkg::pixel_type px);
      int pos;
      if (window_px.size() < WINDOW_DEPTH) begin
         pos = window_px.size();
         while (pos > 0 && window_px[pos-1] > px) pos--;
         window_px.insert(pos, px);
      end else begin
         window_dropped = 1'b1;
      end
   endfunction

   function automatic median_word_type close_window();
      median_word_type word;
      word.median   = window_px[window_px.size() / 2];
      word.overflow = window_dropped;
      window_px.delete();
      window_dropped = 1'b0;
      return word;
   endfunction

   always @(posedge clock) begin
      median_word_type predicted;
      if (!reset && req_ch_if.valid && req_ch_if.ready) begin
         words_taken++;
         absorb_pixel(req_ch_if.pixel);
         if (req_ch_if.last) begin
            predicted = close_window();
            windows_seen++;
            if (predicted.overflow) overflow_seen++;
            if (word_typed) pending_medians.push_back(word_fixed);
            else pending_medians.push_back(predicted);
         end
      end
   end

   always @(posedge clock) begin
      median_word_type want;
      if (!reset && rsp_ch_if.valid && rsp_ch_if.ready) begin
         if (pending_medians.size() == 0) begin
            $error("median word arrived with no window closed: median %0d, overflow %0d",
                   rsp_ch_if.median, rsp_ch_if.overflow);
            mismatches++;
         end else begin
            want = pending_medians.pop_front();
            medians_seen++;
            if (rsp_ch_if.median !== want.median) begin
               $error("median: expected %0d, actual %0d", want.median, rsp_ch_if.median);
               mismatches++;
            end
            if (rsp_ch_if.overflow !== want.overflow) begin
               $error("overflow: expected %0d, actual %0d", want.overflow,
                      rsp_ch_if.overflow);
               mismatches++;
            end
         end
      end
   end

   // Result side: random stalls, plus a long hold-off counted here when requested.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ch_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_word(wmed_pkg::pixel_type px, logic close, logic typed,
                            median_word_type fixed);
      while ($urandom_range(99) < idle_pct) begin
         req_ch_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch_if.valid <= 1'b1;
      req_ch_if.pixel <= px;
      req_ch_if.last  <= close;
      word_typed      <= typed;
      word_fixed      <= fixed;
      words_sent++;
      do @(posedge clock); while (!req_ch_if.ready);
   endtask

   task automatic send_random_window(int len);
      pixel_style_type     style;
      int                  base;
      wmed_pkg::pixel_type px;
      style = pixel_style_type'($urandom_range(3));
      base  = $urandom_range(255);
      for (int i = 0; i < len; i++) begin
         case (style)
            SPREAD:     px = wmed_pkg::pixel_type'($urandom);
            CLUSTER:    px = wmed_pkg::pixel_type'(base + $urandom_range(3));
            EXTREMES:   px = $urandom_range(1) ? 8'hFF : 8'h00;
            default:    px = wmed_pkg::pixel_type'(255 - i * 7);
         endcase
         send_word(px, i == len - 1, 1'b0, '0);
      end
   endtask

   function automatic int random_window_len();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return $urandom_range(12, 1);
      if (sel < 88) return $urandom_range(WINDOW_DEPTH, 13);
      if (sel < 97) return $urandom_range(WINDOW_DEPTH + 13, WINDOW_DEPTH + 1);
      return WINDOW_DEPTH;
   endfunction

   // Always waits on a clock edge before checking, so the closing word of the last window is counted first.
   task automatic wait_all_medians();
      do @(posedge clock); while (pending_medians.size() != 0);
   endtask

   initial begin
      int phase_target;
      reset           = 1'b1;
      req_ch_if.valid = 1'b0;
      req_ch_if.pixel = '0;
      req_ch_if.last  = 1'b0;
      word_typed      = 1'b0;
      word_fixed      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_ROWS; r++) begin
         for (int k = 0; k < stim_rows[r].count; k++) begin
            send_word(stim_rows[r].pixel,
                      stim_rows[r].close && (k == stim_rows[r].count - 1),
                      stim_rows[r].typed && (k == stim_rows[r].count - 1),
                      {stim_rows[r].exp_median, stim_rows[r].exp_overflow});
         end
      end
      req_ch_if.valid <= 1'b0;
      wait_all_medians();

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct     = idle_mix[phase];
         stall_pct    = stall_mix[phase];
         phase_target = words_sent + PHASE_WORDS;
         while (words_sent < phase_target) send_random_window(random_window_len());
         if (phase == 0) begin
            // Hold the result side off while whole windows keep coming, so the result
            // register stays full and the closing cycle backs up into the input.
            hold_request = HOLD_CYCLES;
            for (int w = 0; w < 3; w++) send_random_window(6);
         end
         req_ch_if.valid <= 1'b0;
         wait_all_medians();
      end

      idle_pct  = 0;
      stall_pct = 0;
      wait_all_medians();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_medians.size() != 0) begin
         $error("%0d median words never arrived", pending_medians.size());
         mismatches++;
      end

      $display("Covered %0d pixel words in %0d windows (%0d with dropped pixels).",
               words_taken, windows_seen, overflow_seen);
      $display("Checked %0d median words across four idle and stall mixes.",
               medians_seen);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d median words outstanding.", pending_medians.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* filelist.f */
rtl/wmed_pkg.sv
rtl/wmed_if.sv
rtl/wmed_cell.sv
rtl/window_median_select_core.sv
rtl/wmed_checker.sv
bench/window_median_select_core_tb.sv
